### rtl/jet_pkg.sv
// Shared types, constants and the microcode table of the Julia escape-time engine.
// Used by jet_seq, jet_datapath and julia_escape_time; depends on nothing else.
`timescale 1ns / 1ps

package jet_pkg;

    localparam int DATA_W  = 32;
    localparam int PROD_W  = 64;
    localparam int PIX_W   = 12;
    localparam int COUNT_W = 9;
    localparam int IDX_W   = 3;
    localparam int PC_W    = 4;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_CONST_RE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CONST_IM  = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_X_RE = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_X_IM = 3'd3;
    localparam logic [IDX_W-1:0] REG_STEP_Y_RE = 3'd4;
    localparam logic [IDX_W-1:0] REG_STEP_Y_IM = 3'd5;
    localparam logic [IDX_W-1:0] REG_ORIGIN_RE = 3'd6;
    localparam logic [IDX_W-1:0] REG_ORIGIN_IM = 3'd7;

    // Microprogram addresses.
    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_START = 4'd1;
    localparam logic [PC_W-1:0] PC_MUL_B = 4'd2;
    localparam logic [PC_W-1:0] PC_LD_IM = 4'd3;
    localparam logic [PC_W-1:0] PC_SQ0   = 4'd4;
    localparam logic [PC_W-1:0] PC_LOOP  = 4'd5;
    localparam logic [PC_W-1:0] PC_SQ    = 4'd6;
    localparam logic [PC_W-1:0] PC_TEST  = 4'd7;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd8;

    typedef enum logic [1:0] {
        MUL_HOLD,
        MUL_START_A,
        MUL_START_B,
        MUL_SQUARE
    } t_mul_op;

    typedef enum logic [1:0] {
        Z_HOLD,
        Z_LOAD_RE,
        Z_LOAD_IM,
        Z_ITER
    } t_z_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_STEP
    } t_cnt_op;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_IN_VALID,
        COND_MORE,
        COND_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic              ready;
        t_mul_op           mul_op;
        t_z_op             z_op;
        t_cnt_op           cnt_op;
        logic              out_load;
        t_cond             cond;
        logic              stay;
        logic [PC_W-1:0]   target;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic iter_more;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic signed [DATA_W-1:0] const_re;
        logic signed [DATA_W-1:0] const_im;
        logic signed [DATA_W-1:0] step_x_re;
        logic signed [DATA_W-1:0] step_x_im;
        logic signed [DATA_W-1:0] step_y_re;
        logic signed [DATA_W-1:0] step_y_im;
        logic signed [DATA_W-1:0] origin_re;
        logic signed [DATA_W-1:0] origin_im;
    } t_cfg;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic fits;
        fits = (&v[PROD_W-1:DATA_W-1]) || !(|v[PROD_W-1:DATA_W-1]);
        if (fits) begin
            sat32 = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // Control store. When the condition holds the step counter jumps to the
    // target; otherwise it either stays or advances.
    function automatic t_ctl ucode(input logic [PC_W-1:0] pc);
        t_ctl c;
        c = '{ready: 1'b0, mul_op: MUL_HOLD, z_op: Z_HOLD, cnt_op: CNT_HOLD,
              out_load: 1'b0, cond: COND_NEVER, stay: 1'b0, target: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                c.ready  = 1'b1;
                c.cond   = COND_IN_VALID;
                c.target = PC_START;
                c.stay   = 1'b1;
            end
            PC_START: begin
                c.mul_op = MUL_START_A;
            end
            PC_MUL_B: begin
                c.mul_op = MUL_START_B;
                c.z_op   = Z_LOAD_RE;
                c.cnt_op = CNT_CLEAR;
            end
            PC_LD_IM: begin
                c.z_op = Z_LOAD_IM;
            end
            PC_SQ0: begin
                c.mul_op = MUL_SQUARE;
            end
            PC_LOOP: begin
                c.z_op = Z_ITER;
            end
            PC_SQ: begin
                c.mul_op = MUL_SQUARE;
            end
            PC_TEST: begin
                c.cnt_op = CNT_STEP;
                c.cond   = COND_MORE;
                c.target = PC_LOOP;
            end
            PC_OUT: begin
                c.out_load = 1'b1;
                c.cond     = COND_OUT_FREE;
                c.target   = PC_IDLE;
                c.stay     = 1'b1;
            end
            default: begin
                c.cond   = COND_NEVER;
                c.stay   = 1'b0;
                c.target = PC_IDLE;
                c.ready  = 1'b0;
            end
        endcase
        // Unused addresses fall back to idle.
        if (pc > PC_OUT) begin
            c.cond = COND_OUT_FREE;
            c.stay = 1'b0;
        end
        return c;
    endfunction

endpackage

### rtl/jet_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  jet_pkg::t_flags        i_flags,
    output jet_pkg::t_ctl          o_ctl,
    output logic [jet_pkg::PC_W-1:0] o_pc
);
    import jet_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctl            w_ctl;
    logic            w_take;

    assign w_ctl = ucode(r_pc);

    always_comb begin
        case (w_ctl.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_IN_VALID: w_take = i_flags.in_valid;
            COND_MORE:     w_take = i_flags.iter_more;
            COND_OUT_FREE: w_take = i_flags.out_free;
            default:       w_take = 1'b0;
        endcase
        if (w_take) begin
            n_pc = w_ctl.target;
        end else if (w_ctl.stay) begin
            n_pc = r_pc;
        end else if (r_pc >= PC_OUT) begin
            n_pc = PC_IDLE;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = w_ctl;
    assign o_pc  = r_pc;

endmodule

### rtl/jet_datapath.sv
// Datapath: three registered 32x32 multipliers, the z registers, saturation,
// escape compare and the iteration counter. Depends on jet_pkg.
`timescale 1ns / 1ps

module jet_datapath #(
    parameter int MAX_ITER      = 256,
    parameter int ESCAPE_RADIUS = 2,
    parameter int COORD_BITS    = 12,
    parameter int FRAC_BITS     = 24,
    parameter int NB            = $clog2(MAX_ITER + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jet_pkg::t_ctl                 i_ctl,
    input  jet_pkg::t_cfg                 i_cfg,
    input  logic                          i_load,
    input  logic [jet_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [jet_pkg::PIX_W-1:0]     i_pixel_y,
    output logic                          o_more,
    output logic [NB-1:0]                 o_n,
    output logic [jet_pkg::COUNT_W-1:0]   o_count
);
    import jet_pkg::*;

    localparam logic [PIX_W-1:0] PIX_MASK = (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}}
                                          : PIX_W'((1 << COORD_BITS) - 1);
    localparam logic [PROD_W-1:0] BOUND =
        PROD_W'(ESCAPE_RADIUS * ESCAPE_RADIUS) << (2 * FRAC_BITS);
    localparam logic [NB-1:0] LAST_N = NB'(MAX_ITER - 1);

    logic [PIX_W-1:0]          r_px, r_py;
    logic signed [DATA_W-1:0]  w_px, w_py;
    logic signed [DATA_W-1:0]  r_zr, r_zi;
    logic signed [PROD_W-1:0]  r_m0, r_m1, r_m2;
    logic [NB-1:0]             r_n;

    logic signed [DATA_W-1:0]  w_a0, w_b0, w_a1, w_b1, w_a2, w_b2;
    logic                      w_en0, w_en12;
    logic signed [PROD_W-1:0]  w_start_re, w_start_im;
    logic signed [PROD_W-1:0]  w_diff, w_re_shr, w_im_shr, w_re_sum, w_im_sum;
    logic [PROD_W-1:0]         w_mag;
    logic                      w_esc;
    logic [NB+COUNT_W-1:0]     w_n_ext;

    assign w_px = {{(DATA_W-PIX_W){1'b0}}, r_px};
    assign w_py = {{(DATA_W-PIX_W){1'b0}}, r_py};

    // Operand selection for the three multipliers.
    always_comb begin
        w_a0 = r_zr;  w_b0 = r_zr;
        w_a1 = r_zi;  w_b1 = r_zi;
        w_a2 = r_zr;  w_b2 = r_zi;
        w_en0  = 1'b0;
        w_en12 = 1'b0;
        case (i_ctl.mul_op)
            MUL_START_A: begin
                w_a0 = w_px; w_b0 = i_cfg.step_x_re;
                w_a1 = w_py; w_b1 = i_cfg.step_y_re;
                w_a2 = w_px; w_b2 = i_cfg.step_x_im;
                w_en0  = 1'b1;
                w_en12 = 1'b1;
            end
            MUL_START_B: begin
                w_a0 = w_py; w_b0 = i_cfg.step_y_im;
                w_en0 = 1'b1;
            end
            MUL_SQUARE: begin
                w_en0  = 1'b1;
                w_en12 = 1'b1;
            end
            default: begin
                w_en0  = 1'b0;
                w_en12 = 1'b0;
            end
        endcase
    end

    // Start value sums and the squaring update, both before saturation.
    assign w_start_re = {{(PROD_W-DATA_W){i_cfg.origin_re[DATA_W-1]}}, i_cfg.origin_re}
                        + r_m0 + r_m1;
    assign w_start_im = {{(PROD_W-DATA_W){i_cfg.origin_im[DATA_W-1]}}, i_cfg.origin_im}
                        + r_m2 + r_m0;
    assign w_diff   = r_m0 - r_m1;
    assign w_re_shr = w_diff >>> FRAC_BITS;
    assign w_im_shr = r_m2 >>> (FRAC_BITS - 1);
    assign w_re_sum = w_re_shr
                      + {{(PROD_W-DATA_W){i_cfg.const_re[DATA_W-1]}}, i_cfg.const_re};
    assign w_im_sum = w_im_shr
                      + {{(PROD_W-DATA_W){i_cfg.const_im[DATA_W-1]}}, i_cfg.const_im};

    // Both squares are non-negative, so their sum fits unsigned in 64 bits.
    assign w_mag = $unsigned(r_m0) + $unsigned(r_m1);
    assign w_esc = (w_mag >= BOUND);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px <= i_pixel_x & PIX_MASK;
            r_py <= i_pixel_y & PIX_MASK;
        end
        if (w_en0) begin
            r_m0 <= w_a0 * w_b0;
        end
        if (w_en12) begin
            r_m1 <= w_a1 * w_b1;
            r_m2 <= w_a2 * w_b2;
        end
        case (i_ctl.z_op)
            Z_LOAD_RE: r_zr <= sat32(w_start_re);
            Z_LOAD_IM: r_zi <= sat32(w_start_im);
            Z_ITER: begin
                r_zr <= sat32(w_re_sum);
                r_zi <= sat32(w_im_sum);
            end
            default: begin
                r_zr <= r_zr;
                r_zi <= r_zi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else begin
            case (i_ctl.cnt_op)
                CNT_CLEAR: r_n <= '0;
                CNT_STEP: begin
                    if (!w_esc) begin
                        r_n <= r_n + 1'b1;
                    end
                end
                default: r_n <= r_n;
            endcase
        end
    end

    assign o_more  = !w_esc && (r_n != LAST_N);
    assign o_n     = r_n;
    assign w_n_ext = {{COUNT_W{1'b0}}, r_n};
    assign o_count = w_n_ext[COUNT_W-1:0];

endmodule

### rtl/julia_escape_time.sv
// Julia set escape-time engine, top level: stream ports, configuration registers,
// output register. Depends on jet_pkg, jet_seq and jet_datapath.
//
// Usage: write the eight Q8.24 registers (index 0 const_re through 7 origin_im)
// through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle. Each transfer
// on the s_ side carries one pixel; one transfer on the m_ side returns its
// iteration count, the step at which |z|^2 first reached the escape radius
// squared, or MAX_ITER when it never did.
// Sequencing: pixels are processed one at a time by a microcoded sequencer. A pixel
// whose count is n passes through the PC_START, PC_MUL_B and PC_LD_IM states to form
// its start value and PC_SQ0 to square it, then through the update, square and test
// states for each of its min(n+1, MAX_ITER) steps, then PC_OUT to load the result;
// the sequencer then returns to idle, where it takes the next pixel.
// The result sits in an output register, so a stalled m_ side does not block
// the next pixel; only a second finished result waits for the register to free.
// Reset (i_rst_n low, synchronous) clears the configuration registers and the
// iteration counter to zero, drops m_tvalid and returns the sequencer to idle.
`timescale 1ns / 1ps

module julia_escape_time #(
    parameter int MAX_ITER      = 256,
    parameter int ESCAPE_RADIUS = 2,
    parameter int COORD_BITS    = 12,
    parameter int FRAC_BITS     = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [jet_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [jet_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata    // [8:0] iteration_count
);
    import jet_pkg::*;

    localparam int NB = $clog2(MAX_ITER + 1);

    t_cfg                r_cfg;
    t_ctl                w_ctl;
    t_flags              w_flags;
    logic [PC_W-1:0]     w_pc;
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_more;
    logic [NB-1:0]       w_n;
    logic [COUNT_W-1:0]  w_count;
    logic                r_m_valid;
    logic [COUNT_W-1:0]  r_m_count;

    assign s_tready   = w_ctl.ready;
    assign w_in_acc   = s_tvalid && w_ctl.ready;
    assign w_out_free = !r_m_valid || m_tready;

    assign w_flags.in_valid  = s_tvalid;
    assign w_flags.iter_more = w_more;
    assign w_flags.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CONST_RE:  r_cfg.const_re  <= i_cfg_data;
                REG_CONST_IM:  r_cfg.const_im  <= i_cfg_data;
                REG_STEP_X_RE: r_cfg.step_x_re <= i_cfg_data;
                REG_STEP_X_IM: r_cfg.step_x_im <= i_cfg_data;
                REG_STEP_Y_RE: r_cfg.step_y_re <= i_cfg_data;
                REG_STEP_Y_IM: r_cfg.step_y_im <= i_cfg_data;
                REG_ORIGIN_RE: r_cfg.origin_re <= i_cfg_data;
                REG_ORIGIN_IM: r_cfg.origin_im <= i_cfg_data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    jet_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl),
        .o_pc    (w_pc)
    );

    jet_datapath #(
        .MAX_ITER      (MAX_ITER),
        .ESCAPE_RADIUS (ESCAPE_RADIUS),
        .COORD_BITS    (COORD_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .NB            (NB)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_cfg     (r_cfg),
        .i_load    (w_in_acc),
        .i_pixel_x (s_tdata[11:0]),
        .i_pixel_y (s_tdata[23:12]),
        .o_more    (w_more),
        .o_n       (w_n),
        .o_count   (w_count)
    );

    // Output register: loaded on the final microcode step once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.out_load && w_out_free) begin
            r_m_valid <= 1'b1;
            r_m_count <= w_count;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{(16-COUNT_W){1'b0}}, r_m_count};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_n <= NB'(MAX_ITER))
        else $error("iteration counter beyond limit");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (w_pc == PC_START))
        else $error("sequencer did not start after a pixel transfer");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(w_pc == PC_OUT))
        else $error("result appeared outside the output step");

endmodule
